[sv/amnco_pkg.sv]
// Shared types, constants and the quarter-wave sine table of the AM/NCO modulator.
// Depends on nothing; used by every module of the block except amnco_ram.
package amnco_pkg;

   // Sine table geometry
   localparam int TABLE_INDEX_BITS = 10;
   localparam int TABLE_SIZE       = 1 << TABLE_INDEX_BITS;
   localparam int QUARTER_SIZE     = TABLE_SIZE / 4;
   localparam int HALF_SIZE        = TABLE_SIZE / 2;
   localparam int QIDX_BITS        = TABLE_INDEX_BITS - 1;

   localparam logic [TABLE_INDEX_BITS-1:0] QUARTER_IDX  = TABLE_INDEX_BITS'(QUARTER_SIZE);
   localparam logic [TABLE_INDEX_BITS-1:0] HALF_IDX     = TABLE_INDEX_BITS'(HALF_SIZE);
   localparam logic [TABLE_INDEX_BITS-1:0] THREE_Q_IDX  =
      TABLE_INDEX_BITS'(HALF_SIZE + QUARTER_SIZE);

   // Field widths
   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int BASE_BITS   = 24;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int REQ_BITS    = SAMPLE_BITS + 2 * BASE_BITS;
   localparam int RSP_BITS    = 2 * BASE_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values
   localparam logic [15:0] GAIN_RESET = 16'd256;

   // Fixed-point constants for the table build (Q30)
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PHASE_STEP = 2'd0,
      CSR_GAIN       = 2'd1,
      CSR_BIAS       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_GAIN,
      MUL_COS,
      MUL_SIN
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VEC_MUL,
      ST_VEC,
      ST_I_MUL,
      ST_Q_MUL,
      ST_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       clear_wr;
      logic       load_in;
      logic       rd_cos;
      logic       ld_sin;
      logic       ld_cos;
      logic       ld_prod;
      mul_op_type mul_op;
      logic       ld_vec;
      logic       ld_i;
      logic       ld_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

   typedef logic [14:0] quarter_table_type [QUARTER_SIZE+1];

   // sin(k/QUARTER_SIZE * pi/2) in Q1.15, Taylor series in Q30, round half up
   function automatic quarter_table_type build_quarter_table();
      quarter_table_type tbl;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint unsigned   r;
      for (int k = 0; k <= QUARTER_SIZE; k++) begin
         x  = (64'(k) * HALF_PI_Q30) / QUARTER_SIZE;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 6;
         r  = (x * t) >> 30;
         r  = (r + 64'd16384) >> 15;
         if (r > 64'd32767) begin
            r = 64'd32767;
         end
         tbl[k] = 15'(r);
      end
      return tbl;
   endfunction

   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();

endpackage

[sv/amnco_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amnco_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/amnco_ctrl.sv]
// Sequencing state machine of the AM/NCO modulator: table fill, then one sample at a time.
// Depends on amnco_pkg.
module amnco_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  amnco_pkg::status_type status,
   output amnco_pkg::cmd_type    cmd
);

   amnco_pkg::state_type state_ff;
   amnco_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amnco_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         amnco_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = amnco_pkg::ST_IDLE;
         end
         amnco_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = amnco_pkg::ST_VEC_MUL;
         end
         amnco_pkg::ST_VEC_MUL: state_in = amnco_pkg::ST_VEC;
         amnco_pkg::ST_VEC:     state_in = amnco_pkg::ST_I_MUL;
         amnco_pkg::ST_I_MUL:   state_in = amnco_pkg::ST_Q_MUL;
         amnco_pkg::ST_Q_MUL:   state_in = amnco_pkg::ST_OUT;
         amnco_pkg::ST_OUT: begin
            if (status.out_free) state_in = amnco_pkg::ST_IDLE;
         end
         default: state_in = amnco_pkg::ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.mul_op = amnco_pkg::MUL_GAIN;
      req_tready = 1'b0;
      unique case (state_ff)
         amnco_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         amnco_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         amnco_pkg::ST_VEC_MUL: begin
            cmd.ld_sin  = 1'b1;
            cmd.rd_cos  = 1'b1;
            cmd.ld_prod = 1'b1;
            cmd.mul_op  = amnco_pkg::MUL_GAIN;
         end
         amnco_pkg::ST_VEC: begin
            cmd.ld_cos = 1'b1;
            cmd.ld_vec = 1'b1;
         end
         amnco_pkg::ST_I_MUL: begin
            cmd.ld_prod = 1'b1;
            cmd.mul_op  = amnco_pkg::MUL_COS;
         end
         amnco_pkg::ST_Q_MUL: begin
            cmd.ld_i    = 1'b1;
            cmd.ld_prod = 1'b1;
            cmd.mul_op  = amnco_pkg::MUL_SIN;
         end
         amnco_pkg::ST_OUT: begin
            cmd.ld_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/amnco_dpath.sv]
// Datapath of the AM/NCO modulator: registers, phase accumulator, sine RAM, shared multiplier.
// Depends on amnco_pkg and amnco_ram.
module amnco_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  amnco_pkg::cmd_type                     cmd,
   output amnco_pkg::status_type                  status,
   input  logic                                   csr_valid,
   input  logic [amnco_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [amnco_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic [amnco_pkg::REQ_BITS-1:0]         req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [amnco_pkg::RSP_BITS-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int IB = amnco_pkg::TABLE_INDEX_BITS;
   localparam int SB = amnco_pkg::SAMPLE_BITS;
   localparam int BB = amnco_pkg::BASE_BITS;
   localparam int PB = amnco_pkg::PROD_BITS;
   localparam int VB = PB - 7;   // floor(amp*gain / 2^8) plus bias, before saturation

   // Configuration
   logic        [amnco_pkg::PHASE_BITS-1:0] phase_step_ff;
   logic signed [SB-1:0]                    gain_ff;
   logic signed [SB-1:0]                    bias_ff;

   // Working state
   logic [amnco_pkg::PHASE_BITS-1:0] phase_ff;
   logic [IB-1:0]                    clr_addr_ff;
   logic [IB-1:0]                    idx_ff;
   logic signed [SB-1:0]             amp_ff;
   logic signed [BB-1:0]             base_i_ff;
   logic signed [BB-1:0]             base_q_ff;
   logic                             last_ff;
   logic signed [SB-1:0]             sin_ff;
   logic signed [SB-1:0]             cos_ff;
   logic signed [SB-1:0]             vec_ff;
   logic signed [PB-1:0]             prod_ff;
   logic signed [BB-1:0]             i_sum_ff;

   // Output register
   logic              out_valid_ff;
   logic [BB-1:0]     out_i_ff;
   logic [BB-1:0]     out_q_ff;
   logic              out_last_ff;

   // Combinational
   logic [IB-1:0]            q_sel;
   logic [14:0]              q_mag;
   logic [SB-1:0]            fill_val;
   logic [IB-1:0]            rd_addr;
   logic [SB-1:0]            rd_data;
   logic signed [SB-1:0]     mul_a;
   logic signed [SB-1:0]     mul_b;
   logic signed [PB-1:0]     mul_p;
   logic signed [VB-1:0]     vec_sum;
   logic signed [SB-1:0]     vec_sat;
   logic signed [BB:0]       i_sum;
   logic signed [BB:0]       q_sum;

   function automatic logic signed [SB-1:0] sat16(input logic signed [VB-1:0] v);
      logic signed [VB-1:0] hi;
      logic signed [VB-1:0] lo;
      hi = {{(VB-SB+1){1'b0}}, {(SB-1){1'b1}}};
      lo = {{(VB-SB+1){1'b1}}, {(SB-1){1'b0}}};
      if (v > hi) return hi[SB-1:0];
      if (v < lo) return lo[SB-1:0];
      return v[SB-1:0];
   endfunction

   function automatic logic signed [BB-1:0] sat24(input logic signed [BB:0] v);
      logic signed [BB:0] hi;
      logic signed [BB:0] lo;
      hi = {2'b00, {(BB-1){1'b1}}};
      lo = {2'b11, {(BB-1){1'b0}}};
      if (v > hi) return hi[BB-1:0];
      if (v < lo) return lo[BB-1:0];
      return v[BB-1:0];
   endfunction

   // Table fill: fold the sweep address onto the first quarter wave
   always_comb begin
      if (clr_addr_ff <= amnco_pkg::QUARTER_IDX) begin
         q_sel = clr_addr_ff;
      end else if (clr_addr_ff <= amnco_pkg::HALF_IDX) begin
         q_sel = amnco_pkg::HALF_IDX - clr_addr_ff;
      end else if (clr_addr_ff <= amnco_pkg::THREE_Q_IDX) begin
         q_sel = clr_addr_ff - amnco_pkg::HALF_IDX;
      end else begin
         q_sel = '0 - clr_addr_ff;   // table size minus address
      end
      q_mag = amnco_pkg::QUARTER_TABLE[q_sel[amnco_pkg::QIDX_BITS-1:0]];
      if (clr_addr_ff > amnco_pkg::HALF_IDX) begin
         fill_val = '0 - {1'b0, q_mag};
      end else begin
         fill_val = {1'b0, q_mag};
      end
   end

   assign status = '{clear_last: (clr_addr_ff == {IB{1'b1}}),
                     out_free:   (!out_valid_ff || rsp_tready)};

   // Sine read: top phase bits on acceptance, quarter turn further for cosine
   assign rd_addr = cmd.rd_cos ? (idx_ff + amnco_pkg::QUARTER_IDX)
                               : phase_ff[amnco_pkg::PHASE_BITS-1 -: IB];

   amnco_ram #(
      .WIDTH (SB),
      .DEPTH (amnco_pkg::TABLE_SIZE)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_wr),
      .wr_addr (clr_addr_ff),
      .wr_data (fill_val),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared multiplier
   always_comb begin
      case (cmd.mul_op)
         amnco_pkg::MUL_GAIN: begin
            mul_a = amp_ff;
            mul_b = gain_ff;
         end
         amnco_pkg::MUL_COS: begin
            mul_a = cos_ff;
            mul_b = vec_ff;
         end
         amnco_pkg::MUL_SIN: begin
            mul_a = sin_ff;
            mul_b = vec_ff;
         end
         default: begin
            mul_a = amp_ff;
            mul_b = gain_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // floor(amp*gain / 2^8) + bias; floor(x*vec / 2^15) + base
   assign vec_sum = VB'($signed(prod_ff[PB-1:8])) + VB'(bias_ff);
   assign vec_sat = sat16(vec_sum);
   assign i_sum   = (BB+1)'(base_i_ff) + (BB+1)'($signed(prod_ff[PB-1:15]));
   assign q_sum   = (BB+1)'(base_q_ff) + (BB+1)'($signed(prod_ff[PB-1:15]));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         gain_ff       <= amnco_pkg::GAIN_RESET;
         bias_ff       <= '0;
         phase_ff      <= '0;
         clr_addr_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               amnco_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_data;
               amnco_pkg::CSR_GAIN:       gain_ff       <= csr_data[SB-1:0];
               amnco_pkg::CSR_BIAS:       bias_ff       <= csr_data[SB-1:0];
               default: ;
            endcase
         end
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.load_in) begin
            phase_ff <= phase_ff + phase_step_ff;
         end
         if (cmd.ld_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         amp_ff    <= req_tdata[SB-1:0];
         base_i_ff <= req_tdata[SB+BB-1:SB];
         base_q_ff <= req_tdata[SB+2*BB-1:SB+BB];
         last_ff   <= req_tlast;
         idx_ff    <= phase_ff[amnco_pkg::PHASE_BITS-1 -: IB];
      end
      if (cmd.ld_sin)  sin_ff   <= rd_data;
      if (cmd.ld_cos)  cos_ff   <= rd_data;
      if (cmd.ld_prod) prod_ff  <= mul_p;
      if (cmd.ld_vec)  vec_ff   <= vec_sat;
      if (cmd.ld_i)    i_sum_ff <= sat24(i_sum);
      if (cmd.ld_out) begin
         out_i_ff    <= i_sum_ff;
         out_q_ff    <= sat24(q_sum);
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_q_ff, out_i_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

[sv/am_nco_modulator.sv]
// AM modulator onto an NCO carrier. No new sample is taken before the last result is in
// the output register, as the single shared 16x16 multiplier (three products) and the
// single read port of the sine RAM (two reads) are used in sequence.
// Reset (synchronous, active high): registers to phase_step 0, gain 1.0, bias 0, phase 0;
// then a fill pass writes all 1024 sine RAM entries, during which req_tready stays low.
// Configuration writes are taken in every cycle outside reset, fill pass included.
module am_nco_modulator (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [amnco_pkg::CSR_IDX_BITS-1:0]  csr_index,  // 0 phase_step, 1 gain, 2 bias
   input  logic [amnco_pkg::CSR_DATA_BITS-1:0] csr_data,
   // Sample input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [amnco_pkg::REQ_BITS-1:0]      req_tdata,  // amplitude[15:0], base_i[39:16],
                                                           // base_q[63:40]
   input  logic                                req_tlast,  // last_in_block
   // Result output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [amnco_pkg::RSP_BITS-1:0]      rsp_tdata,  // out_i[23:0], out_q[47:24]
   output logic                                rsp_tlast   // last_of_block
);

   amnco_pkg::cmd_type    cmd;
   amnco_pkg::status_type status;

   // Register writes never stall
   assign csr_ready = 1'b1;

   // Sequencer: fill pass, then accept / vector / cos / sin / output steps
   amnco_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic, phase accumulator, sine RAM and output register
   amnco_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
